// ----- rtl/core/fbp_pkg.sv -----
// ----------------------------------------------------------------------------
// fbp_pkg: shared types and constants of the fixed block pool allocator
// Widths, action and status codes, register indexes and the divider result.
// ----------------------------------------------------------------------------
package fbp_pkg;

    // Pool limits
    localparam int MAX_CHUNKS        = 256;
    localparam int MAX_CHUNK_BYTES   = 4096;
    localparam int RESET_CHUNK_SIZE  = 64;
    localparam int RESET_CHUNK_COUNT = 256;

    // Field and storage widths
    localparam int LINK_W     = $clog2(MAX_CHUNKS);
    localparam int COUNT_W    = $clog2(MAX_CHUNKS + 1);
    localparam int SIZE_W     = 13;
    localparam int REQ_W      = 16;
    localparam int OFFSET_W   = 20;
    localparam int USED_W     = 21;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = OFFSET_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic [LINK_W-1:0]     t_link;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [SIZE_W-1:0]     t_size;
    typedef logic [OFFSET_W-1:0]   t_offset;
    typedef logic [USED_W-1:0]     t_used;
    typedef logic [ACTION_W-1:0]   t_action;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Action codes
    localparam t_action ACT_ALLOC = 2'd0;
    localparam t_action ACT_FREE  = 2'd1;
    localparam t_action ACT_CHECK = 2'd2;

    // Status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_TOO_LARGE = 2'd1;
    localparam t_status ST_NO_CHUNKS = 2'd2;
    localparam t_status ST_BAD_FREE  = 2'd3;

    // Register indexes
    localparam t_cfg_idx CFG_CHUNK_SIZE  = 4'd0;
    localparam t_cfg_idx CFG_CHUNK_COUNT = 4'd1;

    // Divider result toward the sequencer
    typedef struct packed {
        logic    done;
        t_offset quot;
        t_size   rem;
    } t_div_res;

endpackage

// ----- rtl/core/fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: fixed-size block pool with a LIFO free list
// Allocates, frees and checks chunks; links live in a RAM, one per chunk.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  request | in        | i_valid / o_ready       | action, request_size, offset
//  result  | out       | o_valid / i_ready       | status, chunk_offset,
//          |           |                         | address_valid, memory_used
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word at a time. Allocate reads the link RAM, then loads the result; a
// rejected allocate or the unused action goes straight to the result load.
// Free and check wait for the 20-step offset divider, then load the result.
// Reset or a write to either register rebuilds the list at once: per-entry
// valid bits clear, and an entry never written reads as its default link. No sweep.
// A register write is taken only between words and holds off a waiting request.
// A result waits in the output register; the next word is accepted meanwhile,
// and its result waits in the final state until the register is taken.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request
    input  logic                i_valid,
    output logic                o_ready,
    input  fbp_pkg::t_action    i_action,
    input  logic [fbp_pkg::REQ_W-1:0] i_request_size,
    input  fbp_pkg::t_offset    i_byte_offset,
    // result
    output logic                o_valid,
    input  logic                i_ready,
    output fbp_pkg::t_status    o_status,
    output fbp_pkg::t_offset    o_chunk_offset,
    output logic                o_address_valid,
    output fbp_pkg::t_used      o_memory_used,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  fbp_pkg::t_cfg_idx   i_cfg_index,
    input  fbp_pkg::t_cfg_data  i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // Clamp register writes into their legal ranges
    function automatic fbp_pkg::t_size clamp_size(input fbp_pkg::t_cfg_data v);
        fbp_pkg::t_size s;
        s = v[fbp_pkg::SIZE_W-1:0];
        if (s == '0) begin
            s = fbp_pkg::SIZE_W'(1);
        end else if (s > fbp_pkg::SIZE_W'(fbp_pkg::MAX_CHUNK_BYTES)) begin
            s = fbp_pkg::SIZE_W'(fbp_pkg::MAX_CHUNK_BYTES);
        end
        return s;
    endfunction

    function automatic fbp_pkg::t_count clamp_count(input fbp_pkg::t_cfg_data v);
        fbp_pkg::t_count c;
        c = v[fbp_pkg::COUNT_W-1:0];
        if (c == '0) begin
            c = fbp_pkg::COUNT_W'(1);
        end else if (c > fbp_pkg::COUNT_W'(fbp_pkg::MAX_CHUNKS)) begin
            c = fbp_pkg::COUNT_W'(fbp_pkg::MAX_CHUNKS);
        end
        return c;
    endfunction

    logic [1:0]                    r_state;
    logic                          r_out_valid;
    fbp_pkg::t_link                r_head;
    fbp_pkg::t_count               r_used;
    logic [fbp_pkg::MAX_CHUNKS-1:0] r_vld;
    fbp_pkg::t_size                r_cs;
    fbp_pkg::t_count               r_count;

    fbp_pkg::t_action              r_act;
    fbp_pkg::t_status              r_st;
    fbp_pkg::t_offset              r_off_res;
    logic                          r_addr_ok;
    fbp_pkg::t_status              r_out_status;
    fbp_pkg::t_offset              r_out_offset;
    logic                          r_out_addr_ok;
    fbp_pkg::t_used                r_out_used;

    logic                          w_acc;
    logic                          w_cfg_wr;
    logic                          w_slot;
    logic                          w_too_large;
    logic                          w_full;
    fbp_pkg::t_count               w_next_idx;
    fbp_pkg::t_link                w_dflt_link;
    fbp_pkg::t_link                w_link;
    fbp_pkg::t_offset              w_count_ext;
    logic                          w_bad_free;
    logic                          w_idx_ok;
    logic [fbp_pkg::LINK_W+fbp_pkg::SIZE_W-1:0]  w_off_prod;
    logic [fbp_pkg::COUNT_W+fbp_pkg::SIZE_W-1:0] w_used_prod;

    logic                          w_ram_we;
    logic                          w_ram_re;
    fbp_pkg::t_link                w_ram_rdata;
    logic                          w_div_start;
    fbp_pkg::t_div_res             w_div;

    // Handshakes and decisions
    always_comb begin
        w_acc       = i_valid && o_ready;
        w_cfg_wr    = i_cfg_valid && o_cfg_ready;
        w_slot      = !r_out_valid || i_ready;
        w_too_large = (i_request_size >
                       {{(fbp_pkg::REQ_W-fbp_pkg::SIZE_W){1'b0}}, r_cs});
        w_full      = (r_used >= r_count);
        // an entry never written links to the next one, the last to zero
        w_next_idx  = fbp_pkg::COUNT_W'(r_head) + fbp_pkg::COUNT_W'(1);
        w_dflt_link = (w_next_idx < r_count) ? w_next_idx[fbp_pkg::LINK_W-1:0] : '0;
        w_link      = r_vld[r_head] ? w_ram_rdata : w_dflt_link;
        w_count_ext = {{(fbp_pkg::OFFSET_W-fbp_pkg::COUNT_W){1'b0}}, r_count};
        w_idx_ok    = (w_div.quot < w_count_ext);
        w_bad_free  = (r_used == '0) || !w_idx_ok;
        w_off_prod  = r_head * r_cs;
        w_used_prod = r_used * r_cs;
        w_div_start = w_acc && ((i_action == fbp_pkg::ACT_FREE) ||
                                (i_action == fbp_pkg::ACT_CHECK));
        w_ram_re    = w_acc && (i_action == fbp_pkg::ACT_ALLOC);
        w_ram_we    = (r_state == S_DIV) && w_div.done &&
                      (r_act == fbp_pkg::ACT_FREE) && !w_bad_free;
    end

    // Take register writes only between words; a write holds off the request
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;

    // Link store: reads and writes are one word apart, so they never collide
    fbp_ram #(
        .WIDTH(fbp_pkg::LINK_W),
        .DEPTH(fbp_pkg::MAX_CHUNKS)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_div.quot[fbp_pkg::LINK_W-1:0]),
        .i_wdata(r_head),
        .i_re   (w_ram_re),
        .i_raddr(r_head),
        .o_rdata(w_ram_rdata)
    );

    fbp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(i_byte_offset),
        .i_divisor (r_cs),
        .o_res     (w_div)
    );

    // Sequencer, list head, count and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_used      <= '0;
            r_vld       <= '0;
            r_cs        <= fbp_pkg::SIZE_W'(fbp_pkg::RESET_CHUNK_SIZE);
            r_count     <= fbp_pkg::COUNT_W'(fbp_pkg::RESET_CHUNK_COUNT);
        end else begin
            // register write rebuilds the list
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    fbp_pkg::CFG_CHUNK_SIZE: begin
                        r_cs   <= clamp_size(i_cfg_data);
                        r_head <= '0;
                        r_used <= '0;
                        r_vld  <= '0;
                    end
                    fbp_pkg::CFG_CHUNK_COUNT: begin
                        r_count <= clamp_count(i_cfg_data);
                        r_head  <= '0;
                        r_used  <= '0;
                        r_vld   <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            // load a new result word, or drop the one taken
            if ((r_state == S_FIN) && w_slot) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_action) inside
                            fbp_pkg::ACT_ALLOC: begin
                                r_state <= (w_too_large || w_full) ? S_FIN : S_ALLOC;
                            end
                            fbp_pkg::ACT_FREE, fbp_pkg::ACT_CHECK: begin
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_ALLOC: begin
                    // pop the head
                    r_head  <= w_link;
                    r_used  <= r_used + 1'b1;
                    r_state <= S_FIN;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        // push the freed chunk
                        if (w_ram_we) begin
                            r_vld[w_div.quot[fbp_pkg::LINK_W-1:0]] <= 1'b1;
                            r_head <= w_div.quot[fbp_pkg::LINK_W-1:0];
                            r_used <= r_used - 1'b1;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_slot) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_acc) begin
            r_act     <= i_action;
            r_off_res <= '0;
            r_addr_ok <= 1'b0;
            if (i_action == fbp_pkg::ACT_ALLOC) begin
                r_st <= w_too_large ? fbp_pkg::ST_TOO_LARGE :
                        w_full      ? fbp_pkg::ST_NO_CHUNKS : fbp_pkg::ST_OK;
            end else begin
                r_st <= fbp_pkg::ST_OK;
            end
        end
        if (r_state == S_ALLOC) begin
            r_off_res <= w_off_prod[fbp_pkg::OFFSET_W-1:0];
        end
        if ((r_state == S_DIV) && w_div.done) begin
            if (r_act == fbp_pkg::ACT_FREE) begin
                r_st <= w_bad_free ? fbp_pkg::ST_BAD_FREE : fbp_pkg::ST_OK;
            end else begin
                r_addr_ok <= w_idx_ok && (w_div.rem == '0);
            end
        end
        if ((r_state == S_FIN) && w_slot) begin
            r_out_status  <= r_st;
            r_out_offset  <= r_off_res;
            r_out_addr_ok <= r_addr_ok;
            r_out_used    <= w_used_prod[fbp_pkg::USED_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_chunk_offset  = r_out_offset;
    assign o_address_valid = r_out_addr_ok;
    assign o_memory_used   = r_out_used;

endmodule

// ----- rtl/core/fbp_ram.sv -----
// ----------------------------------------------------------------------------
// fbp_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/fbp_div.sv -----
// ----------------------------------------------------------------------------
// fbp_div: restoring divider for byte offset by chunk size
// One quotient bit per cycle; done is shown for one cycle after the last step.
// ----------------------------------------------------------------------------
module fbp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fbp_pkg::t_offset  i_dividend,
    input  fbp_pkg::t_size    i_divisor,
    output fbp_pkg::t_div_res o_res
);

    logic                          r_busy;
    logic [fbp_pkg::DIV_CNT_W-1:0] r_cnt;
    fbp_pkg::t_offset              r_quot;
    fbp_pkg::t_size                r_rem;
    fbp_pkg::t_size                r_divisor;

    logic [fbp_pkg::SIZE_W:0] w_shift;
    logic [fbp_pkg::SIZE_W:0] w_diff;
    logic                     w_ge;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_shift = {r_rem, r_quot[fbp_pkg::OFFSET_W-1]};
        w_ge    = (w_shift >= {1'b0, r_divisor});
        w_diff  = w_shift - {1'b0, r_divisor};
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= fbp_pkg::DIV_CNT_W'(fbp_pkg::DIV_STEPS);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_quot <= {r_quot[fbp_pkg::OFFSET_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[fbp_pkg::SIZE_W-1:0] : w_shift[fbp_pkg::SIZE_W-1:0];
        end
    end

    assign o_res.done = r_busy && (r_cnt == '0);
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

// ----- rtl/core/fbp_checker.sv -----
// ----------------------------------------------------------------------------
// fbp_checker: port-level checks of the fixed block pool allocator
// Watches the top-level ports only; attached by a bind statement.
// ----------------------------------------------------------------------------
module fbp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input fbp_pkg::t_status    o_status,
    input fbp_pkg::t_offset    o_chunk_offset,
    input logic                o_address_valid,
    input fbp_pkg::t_used      o_memory_used
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

    // One word in flight: accept drops ready for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word accepted back to back");

    // A stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) &&
                                   $stable(o_chunk_offset) && $stable(o_memory_used)))
        else $error("stalled result word changed");

    // Failed words carry no chunk offset
    a_fail_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != fbp_pkg::ST_OK)) |-> (o_chunk_offset == '0))
        else $error("failed word carries a chunk offset");

    // A good address is only reported with status ok and no offset
    a_check_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_address_valid) |->
            ((o_status == fbp_pkg::ST_OK) && (o_chunk_offset == '0)))
        else $error("address check result mixed with another action");

endmodule

bind fixed_block_pool_allocator fbp_checker u_fbp_checker (.*);

// ----- tb/tb_fixed_block_pool_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator: self-checking bench for the block pool
// Drives allocate, free and check words under random idling, predicts every
// result from a free-list model kept in the bench, and compares field by field.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;

    localparam fbp_pkg::t_action  ACT_UNUSED     = 2'd3;
    localparam fbp_pkg::t_cfg_idx CFG_UNUSED     = 4'hF;
    localparam int                HOLD_CYCLES    = 400;
    localparam int                WATCHDOG_LIMIT = 3000;
    localparam int                DRAIN_CYCLES   = 40;

    typedef struct packed {
        fbp_pkg::t_status status;
        fbp_pkg::t_offset chunk_offset;
        logic             address_valid;
        fbp_pkg::t_used   memory_used;
    } t_pool_result;

    // DUT ports
    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_valid         = 1'b0;
    logic                        o_ready;
    fbp_pkg::t_action            i_action        = fbp_pkg::ACT_ALLOC;
    logic [fbp_pkg::REQ_W-1:0]   i_request_size  = '0;
    fbp_pkg::t_offset            i_byte_offset   = '0;
    logic                        o_valid;
    logic                        i_ready         = 1'b0;
    fbp_pkg::t_status            o_status;
    fbp_pkg::t_offset            o_chunk_offset;
    logic                        o_address_valid;
    fbp_pkg::t_used              o_memory_used;
    logic                        i_cfg_valid     = 1'b0;
    logic                        o_cfg_ready;
    fbp_pkg::t_cfg_idx           i_cfg_index     = fbp_pkg::CFG_CHUNK_SIZE;
    fbp_pkg::t_cfg_data          i_cfg_data      = '0;

    // Pool model state
    int unsigned                 pool_chunk_bytes;
    int unsigned                 pool_chunk_total;
    int unsigned                 free_top;
    int unsigned                 chunks_taken;
    fbp_pkg::t_link              link_ram [fbp_pkg::MAX_CHUNKS];
    fbp_pkg::t_offset            live_chunks [$];
    t_pool_result                expected_q [$];
    t_pool_result                want_r;

    // Run control and statistics
    logic                sender_idles    = 1'b1;
    logic                receiver_idles  = 1'b1;
    logic                hold_request    = 1'b0;
    int                  ready_gap       = 0;
    int                  quiet_cycles    = 0;
    int                  fail_count      = 0;
    int                  items_sent      = 0;
    int                  results_checked = 0;
    int                  writes_done     = 0;
    int                  holds_done      = 0;
    int                  addr_hits       = 0;
    int                  status_seen [4] = '{0, 0, 0, 0};

    fixed_block_pool_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_request_size  (i_request_size),
        .i_byte_offset   (i_byte_offset),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_chunk_offset  (o_chunk_offset),
        .o_address_valid (o_address_valid),
        .o_memory_used   (o_memory_used),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------

    // Relink every entry to its successor and empty the pool
    function automatic void rebuild_free_list();
        for (int i = 0; i < fbp_pkg::MAX_CHUNKS; i++) begin
            link_ram[i] = (i + 1 < pool_chunk_total) ? fbp_pkg::t_link'(i + 1) : '0;
        end
        free_top     = 0;
        chunks_taken = 0;
        live_chunks.delete();
    endfunction

    function automatic int unsigned clamp_value(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        if (v < lo) begin
            return lo;
        end
        return (v > hi) ? hi : v;
    endfunction

    // Apply a register write; unused indexes leave the pool alone
    function automatic void apply_register(fbp_pkg::t_cfg_idx idx,
                                           fbp_pkg::t_cfg_data data);
        if (idx == fbp_pkg::CFG_CHUNK_SIZE) begin
            pool_chunk_bytes = clamp_value(data, 1, fbp_pkg::MAX_CHUNK_BYTES);
            rebuild_free_list();
        end else if (idx == fbp_pkg::CFG_CHUNK_COUNT) begin
            pool_chunk_total = clamp_value(data[fbp_pkg::COUNT_W-1:0], 1,
                                           fbp_pkg::MAX_CHUNKS);
            rebuild_free_list();
        end
    endfunction

    // Advance the pool by one request word and return its result
    function automatic t_pool_result predict_pool(fbp_pkg::t_action act,
                                                  logic [fbp_pkg::REQ_W-1:0] req,
                                                  fbp_pkg::t_offset off);
        t_pool_result r;
        int unsigned  idx;
        r = '0;
        case (act)
            fbp_pkg::ACT_ALLOC: begin
                if (req > pool_chunk_bytes) begin
                    r.status = fbp_pkg::ST_TOO_LARGE;
                end else if (chunks_taken >= pool_chunk_total) begin
                    r.status = fbp_pkg::ST_NO_CHUNKS;
                end else begin
                    r.chunk_offset = fbp_pkg::t_offset'(free_top * pool_chunk_bytes);
                    free_top       = link_ram[free_top];
                    chunks_taken++;
                end
            end
            fbp_pkg::ACT_FREE: begin
                idx = off / pool_chunk_bytes;
                if (chunks_taken == 0 || idx >= pool_chunk_total) begin
                    r.status = fbp_pkg::ST_BAD_FREE;
                end else begin
                    link_ram[idx] = fbp_pkg::t_link'(free_top);
                    free_top      = idx;
                    chunks_taken--;
                end
            end
            fbp_pkg::ACT_CHECK: begin
                r.address_valid = (off < pool_chunk_bytes * pool_chunk_total) &&
                                  (off % pool_chunk_bytes == 0);
            end
            default: ;
        endcase
        r.memory_used = fbp_pkg::t_used'(chunks_taken * pool_chunk_bytes);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one request word, hold it until taken, and log its result
    task automatic send_request(fbp_pkg::t_action act, logic [fbp_pkg::REQ_W-1:0] req,
                                fbp_pkg::t_offset off);
        t_pool_result exp_r;
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_action       = act;
        i_request_size = req;
        i_byte_offset  = off;
        do @(posedge i_clk); while (!o_ready);
        exp_r = predict_pool(act, req, off);
        expected_q.push_back(exp_r);
        if (act == fbp_pkg::ACT_ALLOC && exp_r.status == fbp_pkg::ST_OK) begin
            live_chunks.push_back(exp_r.chunk_offset);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // Write one register once the block has drained
    task automatic write_register(fbp_pkg::t_cfg_idx idx, fbp_pkg::t_cfg_data data);
        i_valid = 1'b0;
        wait (expected_q.size() == 0);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        writes_done++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly alloc/free pairs on live chunks and checks, with some noise
    task automatic send_random_request();
        int unsigned               pick;
        int unsigned               k;
        fbp_pkg::t_action          act;
        logic [fbp_pkg::REQ_W-1:0] req;
        fbp_pkg::t_offset          off;
        pick = $urandom_range(0, 99);
        act  = fbp_pkg::ACT_ALLOC;
        req  = fbp_pkg::REQ_W'($urandom);
        off  = fbp_pkg::t_offset'($urandom);
        if (pick < 40) begin
            case ($urandom_range(0, 9))
                0:       req = fbp_pkg::REQ_W'(pool_chunk_bytes + 1);
                1:       req = fbp_pkg::REQ_W'(pool_chunk_bytes);
                default: req = fbp_pkg::REQ_W'($urandom_range(0, pool_chunk_bytes));
            endcase
        end else if (pick < 70 && live_chunks.size() > 0) begin
            act = fbp_pkg::ACT_FREE;
            k   = $urandom_range(0, live_chunks.size() - 1);
            off = fbp_pkg::t_offset'(live_chunks[k] +
                  ($urandom_range(0, 1) ? $urandom_range(0, pool_chunk_bytes - 1) : 0));
            live_chunks.delete(k);
        end else if (pick < 85) begin
            act = fbp_pkg::ACT_CHECK;
            off = fbp_pkg::t_offset'($urandom_range(0, pool_chunk_total) * pool_chunk_bytes +
                  ($urandom_range(0, 2) == 0 ? $urandom_range(0, pool_chunk_bytes - 1) : 0));
        end else begin
            act = fbp_pkg::t_action'($urandom_range(0, 3));
        end
        send_request(act, req, off);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry: field extremes, every action and the error paths
    task automatic test_directed_ops();
        send_request(fbp_pkg::ACT_FREE,   16'd0,     20'd0);
        send_request(fbp_pkg::ACT_CHECK,  16'd0,     20'd0);
        send_request(fbp_pkg::ACT_CHECK,  16'd0,     20'd16320);
        send_request(fbp_pkg::ACT_CHECK,  16'd0,     20'd16384);
        send_request(fbp_pkg::ACT_CHECK,  16'd0,     20'd65);
        send_request(fbp_pkg::ACT_CHECK,  16'hFFFF,  20'hFFFFF);
        send_request(fbp_pkg::ACT_ALLOC,  16'd0,     20'd0);
        send_request(fbp_pkg::ACT_ALLOC,  16'd64,    20'hFFFFF);
        send_request(fbp_pkg::ACT_ALLOC,  16'd65,    20'd0);
        send_request(fbp_pkg::ACT_ALLOC,  16'hFFFF,  20'd0);
        // unaligned free lands on the chunk that holds it
        send_request(fbp_pkg::ACT_FREE,   16'd0,     20'd127);
        send_request(fbp_pkg::ACT_FREE,   16'd0,     20'd16384);
        send_request(fbp_pkg::ACT_FREE,   16'hFFFF,  20'hFFFFF);
        send_request(fbp_pkg::ACT_ALLOC,  16'd1,     20'd0);
        send_request(fbp_pkg::ACT_ALLOC,  16'd63,    20'd0);
        // double free goes through undetected
        send_request(fbp_pkg::ACT_FREE,   16'd0,     20'd128);
        send_request(fbp_pkg::ACT_FREE,   16'd0,     20'd128);
        send_request(ACT_UNUSED,          16'hFFFF,  20'hFFFFF);
        send_request(fbp_pkg::ACT_ALLOC,  16'd0,     20'd0);
    endtask

    // Register clamps at both ends, and a write to an unused index
    task automatic test_register_extremes();
        write_register(fbp_pkg::CFG_CHUNK_COUNT, '0);
        send_request(fbp_pkg::ACT_ALLOC, 16'd0,  20'd0);
        send_request(fbp_pkg::ACT_ALLOC, 16'd0,  20'd0);
        send_request(fbp_pkg::ACT_CHECK, 16'd0,  20'd0);
        send_request(fbp_pkg::ACT_CHECK, 16'd0,  20'd64);
        send_request(fbp_pkg::ACT_FREE,  16'd0,  20'd63);
        send_request(fbp_pkg::ACT_FREE,  16'd0,  20'd0);
        write_register(fbp_pkg::CFG_CHUNK_SIZE, '0);
        send_request(fbp_pkg::ACT_ALLOC, 16'd2,  20'd0);
        send_request(fbp_pkg::ACT_ALLOC, 16'd1,  20'd0);
        send_request(fbp_pkg::ACT_CHECK, 16'd0,  20'd1);
        write_register(fbp_pkg::CFG_CHUNK_COUNT, 13'h1FFF);
        send_request(fbp_pkg::ACT_ALLOC, 16'd1,  20'd0);
        send_request(fbp_pkg::ACT_ALLOC, 16'd0,  20'd0);
        write_register(CFG_UNUSED, 13'h1FFF);
        send_request(fbp_pkg::ACT_ALLOC, 16'd0,  20'd0);
        send_request(fbp_pkg::ACT_FREE,  16'd0,  20'd1);
        send_request(fbp_pkg::ACT_CHECK, 16'd0,  20'd255);
        send_request(fbp_pkg::ACT_CHECK, 16'd0,  20'd256);
        write_register(fbp_pkg::CFG_CHUNK_SIZE, 13'h1FFF);
        send_request(fbp_pkg::ACT_ALLOC, 16'd4097, 20'd0);
        send_request(fbp_pkg::ACT_ALLOC, 16'd4096, 20'd0);
        send_request(fbp_pkg::ACT_CHECK, 16'd0,    20'd4096);
        write_register(fbp_pkg::CFG_CHUNK_COUNT, 13'h200);
        send_request(fbp_pkg::ACT_ALLOC, 16'd0,  20'd0);
        send_request(fbp_pkg::ACT_ALLOC, 16'd0,  20'd0);
    endtask

    // Largest pool filled to the last chunk, then mixed traffic on it
    task automatic test_fill_pool();
        write_register(fbp_pkg::CFG_CHUNK_SIZE,  13'd4096);
        write_register(fbp_pkg::CFG_CHUNK_COUNT, 13'd256);
        repeat (fbp_pkg::MAX_CHUNKS + 1) begin
            send_request(fbp_pkg::ACT_ALLOC, fbp_pkg::REQ_W'($urandom_range(0, 4096)),
                         fbp_pkg::t_offset'($urandom));
        end
        send_request(fbp_pkg::ACT_CHECK, 16'd0, 20'd1044480);
        send_request(fbp_pkg::ACT_FREE,  16'd0, 20'hFFFFF);
        send_request(fbp_pkg::ACT_ALLOC, 16'd0, 20'd0);
        repeat (40) send_random_request();
    endtask

    // Several random geometries, raw register values included
    task automatic test_random_traffic();
        fbp_pkg::t_cfg_data size_word;
        fbp_pkg::t_cfg_data count_word;
        repeat (5) begin
            case ($urandom_range(0, 4))
                0:       size_word = fbp_pkg::t_cfg_data'($urandom_range(1, 8));
                1:       size_word = 13'd4096;
                2:       size_word = fbp_pkg::t_cfg_data'(1 << $urandom_range(0, 12));
                3:       size_word = fbp_pkg::t_cfg_data'($urandom_range(0, 8191));
                default: size_word = fbp_pkg::t_cfg_data'($urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 3))
                0:       count_word = fbp_pkg::t_cfg_data'($urandom_range(1, 4));
                1:       count_word = 13'd256;
                2:       count_word = fbp_pkg::t_cfg_data'($urandom_range(0, 511));
                default: count_word = fbp_pkg::t_cfg_data'($urandom_range(1, 256));
            endcase
            write_register(fbp_pkg::CFG_CHUNK_SIZE,  size_word);
            write_register(fbp_pkg::CFG_CHUNK_COUNT, count_word);
            repeat (25) send_random_request();
        end
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        write_register(fbp_pkg::CFG_CHUNK_SIZE,  13'd16);
        write_register(fbp_pkg::CFG_CHUNK_COUNT, 13'd8);
        hold_request = 1'b1;
        repeat (24) send_random_request();
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_steady_stream();
        write_register(fbp_pkg::CFG_CHUNK_SIZE,  13'd32);
        write_register(fbp_pkg::CFG_CHUNK_COUNT, 13'd12);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (60) send_random_request();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch at result %0d: %s", $realtime, results_checked, msg);
        fail_count++;
    endtask

    // Drive ready with random stall bursts and the one long hold
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready      = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end
            if (ready_gap > 0) begin
                i_ready = 1'b0;
                ready_gap--;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                i_ready   = 1'b0;
                ready_gap = $urandom_range(0, 6);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Compare each taken result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result word with no request pending");
            end else begin
                want_r = expected_q.pop_front();
                if (o_status !== want_r.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want_r.status));
                if (o_chunk_offset !== want_r.chunk_offset)
                    report_mismatch($sformatf("chunk_offset got %0d want %0d",
                                              o_chunk_offset, want_r.chunk_offset));
                if (o_address_valid !== want_r.address_valid)
                    report_mismatch($sformatf("address_valid got %0b want %0b",
                                              o_address_valid, want_r.address_valid));
                if (o_memory_used !== want_r.memory_used)
                    report_mismatch($sformatf("memory_used got %0d want %0d",
                                              o_memory_used, want_r.memory_used));
            end
            results_checked++;
            status_seen[o_status]++;
            if (o_address_valid === 1'b1) addr_hits++;
        end
    end

    // Stop the run when no word moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        pool_chunk_bytes = fbp_pkg::RESET_CHUNK_SIZE;
        pool_chunk_total = fbp_pkg::RESET_CHUNK_COUNT;
        rebuild_free_list();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_ops();
        test_register_extremes();
        test_fill_pool();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();

        // Drain and let any stray word show up
        i_valid = 1'b0;
        wait (expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d request words, %0d register writes, %0d long receiver holds",
                 items_sent, writes_done, holds_done);
        $display("results: ok %0d, too large %0d, out of chunks %0d, bad free %0d, addr hits %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], addr_hits);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
